FILE: src/sqd_pkg.sv
// Shared constants, payload types and helpers for the shortest-queue dispatcher.
`timescale 1ns / 1ps
package sqd_pkg;

	localparam int NUM_SERVERS = 4;
	localparam int QUEUE_DEPTH = 64;
	localparam int WORK_LIMIT  = 256;

	// Fixed field widths of the words on the ports
	localparam int OP_W      = 1;
	localparam int WORK_IN_W = 8;
	localparam int ID_W      = 16;
	localparam int SERVER_W  = 2;
	localparam int REM_W     = 8;
	localparam int QLEN_W    = 7;

	// Internal widths
	localparam int SRV_W  = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int WORK_W = $clog2(WORK_LIMIT);
	localparam int SLOTS  = NUM_SERVERS * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);

	typedef enum logic [OP_W-1:0] {
		OP_ARRIVAL = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		EV_QUEUED   = 2'd0,
		EV_SERVED   = 2'd1,
		EV_DEPARTED = 2'd2,
		EV_REFUSED  = 2'd3
	} evt_t;

	typedef struct packed {
		op_t                  operation;
		logic [WORK_IN_W-1:0] work_amount;
	} req_t;

	typedef struct packed {
		evt_t                event_res;
		logic [ID_W-1:0]     job_id;
		logic [SERVER_W-1:0] server;
		logic [REM_W-1:0]    remaining_work;
		logic [QLEN_W-1:0]   queue_length;
		logic                last;
	} rsp_t;

	// Classified command handed from the front to the back
	typedef struct packed {
		logic              is_tick;
		logic [WORK_W-1:0] work;
	} cmd_t;

	// One job entry of the store
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [WORK_W-1:0] work;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARR_SCAN,
		ST_ARR_EMIT,
		ST_TICK_SCAN,
		ST_TICK_EMIT
	} back_state_t;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SRV_W-1:0] srv,
		input logic [PTR_W-1:0] ptr);
		slot_addr = ADDR_W'(ADDR_W'(srv) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(ptr);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
		if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
			ptr_next = '0;
		end else begin
			ptr_next = ptr + 1'b1;
		end
	endfunction

endpackage

FILE: src/shortest_queue_dispatcher_top.sv
// Top level of the join-shortest-queue dispatcher: front, command queue, back.
//
//   channel  handshake              word
//   req      req_valid/req_ready    req_data  (operation, work_amount)
//   rsp      rsp_valid/rsp_ready    rsp_data  (event_res, job_id, server,
//                                              remaining_work, queue_length, last)
//   cfg      cfg_valid/cfg_ready    cfg_data  (job_limit)
//
// An arrival in the back compares the fill counts one FIFO at a time, then
// dispatches. A tick visits each FIFO up to the last busy one, skipping an empty
// one and doing a store read, then an update, for a busy one.
// Commands pass through the front register and the two-entry queue.
// Reset leaves all FIFOs empty and job_limit at 65535; the job store needs no
// clearing. A stalled rsp channel holds the back; the front keeps taking words
// until the queue fills. cfg is always ready.
`timescale 1ns / 1ps
module shortest_queue_dispatcher_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  sqd_pkg::req_t            req_data,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output sqd_pkg::rsp_t            rsp_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [sqd_pkg::ID_W-1:0] cfg_data
);
	import sqd_pkg::*;

	logic [ID_W-1:0] job_limit_q;
	logic            fr_valid;
	logic            fr_ready;
	cmd_t            fr_cmd;
	logic            q_valid;
	logic            q_pop;
	cmd_t            q_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_limit_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			job_limit_q <= cfg_data;
		end
	end

	sqd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd_data  (fr_cmd)
	);

	sqd_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_data  (fr_cmd),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_data  (q_cmd)
	);

	sqd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_limit (job_limit_q),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd_data  (q_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

FILE: src/sqd_front.sv
// Input stage: registers each request word and turns it into a command.
`timescale 1ns / 1ps
module sqd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sqd_pkg::req_t req_data,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output sqd_pkg::cmd_t cmd_data
);
	import sqd_pkg::*;

	logic valid_q;
	cmd_t cmd_q;
	cmd_t cmd_d;

	assign req_ready = !valid_q || cmd_ready;
	assign cmd_valid = valid_q;
	assign cmd_data  = cmd_q;

	// Classify and saturate the work amount
	always_comb begin
		cmd_d.is_tick = (req_data.operation == OP_TICK);
		if (32'(req_data.work_amount) > WORK_LIMIT - 1) begin
			cmd_d.work = WORK_W'(WORK_LIMIT - 1);
		end else begin
			cmd_d.work = WORK_W'(req_data.work_amount);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_q <= 1'b1;
		end else if (cmd_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q <= cmd_d;
		end
	end

endmodule

FILE: src/sqd_cmd_fifo.sv
// Two-entry command queue between the front and the back.
`timescale 1ns / 1ps
module sqd_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  sqd_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_pop,
	output sqd_pkg::cmd_t rd_data
);
	import sqd_pkg::*;

	cmd_t       slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = slots_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: src/sqd_back.sv
// Execution stage: server FIFOs, job store, dispatch and service sequencer.
`timescale 1ns / 1ps
module sqd_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [sqd_pkg::ID_W-1:0] job_limit,
	input  logic                     cmd_valid,
	output logic                     cmd_pop,
	input  sqd_pkg::cmd_t            cmd_data,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output sqd_pkg::rsp_t            rsp_data
);
	import sqd_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [SRV_W-1:0]  srv_q;
	logic [SRV_W-1:0]  srv_d;
	logic [SRV_W-1:0]  best_q;
	logic [SRV_W-1:0]  best_d;
	logic [FILL_W-1:0] best_fill_q;
	logic [FILL_W-1:0] best_fill_d;

	logic [PTR_W-1:0]  head_q [NUM_SERVERS];
	logic [PTR_W-1:0]  tail_q [NUM_SERVERS];
	logic [FILL_W-1:0] fill_q [NUM_SERVERS];
	logic [ID_W-1:0]   issued_q;

	entry_t            mem [SLOTS];
	entry_t            rd_data_q;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	entry_t            mem_wdata;

	logic              out_valid_q;
	rsp_t              out_q;
	rsp_t              out_d;
	logic              emit_ok;
	logic              arr_fire;
	logic              tick_fire;
	logic              refuse;
	logic              later_busy;
	logic              at_last_srv;
	logic [ID_W-1:0]   new_id;
	logic [WORK_W-1:0] work_dec;
	logic              head_done;

	assign rsp_valid   = out_valid_q;
	assign rsp_data    = out_q;
	assign emit_ok     = !out_valid_q || rsp_ready;
	assign at_last_srv = (srv_q == SRV_W'(NUM_SERVERS - 1));
	assign new_id      = issued_q + 1'b1;
	assign refuse      = (issued_q >= job_limit) || (best_fill_q >= FILL_W'(QUEUE_DEPTH));
	assign work_dec    = rd_data_q.work - 1'b1;
	assign head_done   = (rd_data_q.work == '0);
	assign rd_addr     = slot_addr(srv_q, head_q[srv_q]);

	// A later FIFO holding jobs means this result is not the final one of the tick
	always_comb begin
		later_busy = 1'b0;
		for (int k = 0; k < NUM_SERVERS; k++) begin
			if (SRV_W'(k) > srv_q && fill_q[k] != '0) begin
				later_busy = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			srv_q       <= '0;
			best_q      <= '0;
			best_fill_q <= '0;
		end else begin
			state_q     <= state_d;
			srv_q       <= srv_d;
			best_q      <= best_d;
			best_fill_q <= best_fill_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		srv_d       = srv_q;
		best_d      = best_q;
		best_fill_d = best_fill_q;
		cmd_pop     = 1'b0;
		rd_en       = 1'b0;
		arr_fire    = 1'b0;
		tick_fire   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd_data.is_tick) begin
						srv_d   = '0;
						state_d = ST_TICK_SCAN;
					end else begin
						best_d      = '0;
						best_fill_d = fill_q[0];
						srv_d       = SRV_W'(1);
						state_d     = ST_ARR_SCAN;
					end
				end
			end
			ST_ARR_SCAN: begin
				// strict less-than keeps ties on the lowest index
				if (fill_q[srv_q] < best_fill_q) begin
					best_d      = srv_q;
					best_fill_d = fill_q[srv_q];
				end
				if (at_last_srv) begin
					state_d = ST_ARR_EMIT;
				end else begin
					srv_d = srv_q + 1'b1;
				end
			end
			ST_ARR_EMIT: begin
				if (emit_ok) begin
					arr_fire = 1'b1;
					cmd_pop  = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_TICK_SCAN: begin
				if (fill_q[srv_q] != '0) begin
					rd_en   = 1'b1;
					state_d = ST_TICK_EMIT;
				end else if (at_last_srv) begin
					cmd_pop = 1'b1;
					state_d = ST_IDLE;
				end else begin
					srv_d = srv_q + 1'b1;
				end
			end
			ST_TICK_EMIT: begin
				if (emit_ok) begin
					tick_fire = 1'b1;
					if (!later_busy) begin
						cmd_pop = 1'b1;
						state_d = ST_IDLE;
					end else begin
						srv_d   = srv_q + 1'b1;
						state_d = ST_TICK_SCAN;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Store write port and result word
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_addr(best_q, tail_q[best_q]);
		mem_wdata = '{id: new_id, work: cmd_data.work};
		out_d     = '0;
		if (arr_fire) begin
			out_d.server = SERVER_W'(best_q);
			out_d.last   = 1'b1;
			if (refuse) begin
				out_d.event_res    = EV_REFUSED;
				out_d.job_id       = '0;
				out_d.remaining_work = '0;
				out_d.queue_length = QLEN_W'(best_fill_q);
			end else begin
				mem_we               = 1'b1;
				out_d.event_res      = EV_QUEUED;
				out_d.job_id         = new_id;
				out_d.remaining_work = REM_W'(cmd_data.work);
				out_d.queue_length   = QLEN_W'(best_fill_q + 1'b1);
			end
		end else if (tick_fire) begin
			mem_waddr    = slot_addr(srv_q, head_q[srv_q]);
			mem_wdata    = '{id: rd_data_q.id, work: work_dec};
			out_d.job_id = rd_data_q.id;
			out_d.server = SERVER_W'(srv_q);
			out_d.last   = !later_busy;
			if (head_done) begin
				out_d.event_res      = EV_DEPARTED;
				out_d.remaining_work = '0;
				out_d.queue_length   = QLEN_W'(fill_q[srv_q] - 1'b1);
			end else begin
				mem_we               = 1'b1;
				out_d.event_res      = EV_SERVED;
				out_d.remaining_work = REM_W'(work_dec);
				out_d.queue_length   = QLEN_W'(fill_q[srv_q]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SERVERS; k++) begin
				head_q[k] <= '0;
				tail_q[k] <= '0;
				fill_q[k] <= '0;
			end
			issued_q <= '0;
		end else if (arr_fire && !refuse) begin
			tail_q[best_q] <= ptr_next(tail_q[best_q]);
			fill_q[best_q] <= best_fill_q + 1'b1;
			issued_q       <= new_id;
		end else if (tick_fire && head_done) begin
			head_q[srv_q] <= ptr_next(head_q[srv_q]);
			fill_q[srv_q] <= fill_q[srv_q] - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// Hold the read word until the head has been handled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (arr_fire || tick_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (arr_fire || tick_fire) begin
			out_q <= out_d;
		end
	end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the join-shortest-queue dispatcher.
`timescale 1ns / 1ps
module testbench;
	import sqd_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 12;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 48;
	localparam int REPORT_MAX    = 10;

	// Tracks the FIFO contents and queues the events each accepted word must produce.
	class dispatch_ledger;
		logic [ID_W-1:0]  slot_id   [NUM_SERVERS][QUEUE_DEPTH];
		logic [REM_W-1:0] slot_work [NUM_SERVERS][QUEUE_DEPTH];
		int unsigned head [NUM_SERVERS];
		int unsigned tail [NUM_SERVERS];
		int unsigned fill [NUM_SERVERS];
		int unsigned issued;
		int unsigned job_limit;
		rsp_t events_due[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned arrivals;
		int unsigned ticks;
		int unsigned limit_refusals;
		int unsigned full_refusals;
		int unsigned departures;

		function new();
			foreach (fill[s]) begin
				head[s] = 0;
				tail[s] = 0;
				fill[s] = 0;
			end
			issued = 0;
			job_limit = 65535;
			mismatches = 0;
			checked = 0;
			arrivals = 0;
			ticks = 0;
			limit_refusals = 0;
			full_refusals = 0;
			departures = 0;
		endfunction

		function void set_limit(input logic [ID_W-1:0] value);
			job_limit = value;
		endfunction

		function int unsigned pending();
			return events_due.size();
		endfunction

		function int unsigned fill_min();
			int unsigned m;
			m = fill[0];
			foreach (fill[s]) begin
				if (fill[s] < m) m = fill[s];
			end
			return m;
		endfunction

		function int unsigned fill_total();
			int unsigned t;
			t = 0;
			foreach (fill[s]) t += fill[s];
			return t;
		endfunction

		function void note_request(input req_t item);
			rsp_t ev;
			int unsigned best;
			int unsigned w;
			int last_busy;
			if (item.operation == OP_ARRIVAL) begin
				arrivals++;
				best = 0;
				for (int s = 1; s < NUM_SERVERS; s++) begin
					if (fill[s] < fill[best]) best = s;
				end
				ev = '0;
				ev.server = SERVER_W'(best);
				ev.last = 1'b1;
				if (issued >= job_limit || fill[best] >= QUEUE_DEPTH) begin
					if (issued >= job_limit) limit_refusals++;
					else full_refusals++;
					ev.event_res = EV_REFUSED;
					ev.queue_length = QLEN_W'(fill[best]);
				end else begin
					w = item.work_amount;
					if (w > WORK_LIMIT - 1) w = WORK_LIMIT - 1;
					issued = (issued + 1) & 32'hFFFF;
					slot_id[best][tail[best]] = ID_W'(issued);
					slot_work[best][tail[best]] = REM_W'(w);
					tail[best] = (tail[best] + 1) % QUEUE_DEPTH;
					fill[best]++;
					ev.event_res = EV_QUEUED;
					ev.job_id = ID_W'(issued);
					ev.remaining_work = REM_W'(w);
					ev.queue_length = QLEN_W'(fill[best]);
				end
				events_due.push_back(ev);
			end else begin
				ticks++;
				// the last busy FIFO carries the closing flag
				last_busy = -1;
				for (int s = 0; s < NUM_SERVERS; s++) begin
					if (fill[s] != 0) last_busy = s;
				end
				for (int s = 0; s < NUM_SERVERS; s++) begin
					if (fill[s] != 0) begin
						ev = '0;
						ev.server = SERVER_W'(s);
						ev.job_id = slot_id[s][head[s]];
						ev.last = (s == last_busy);
						if (slot_work[s][head[s]] != 0) begin
							slot_work[s][head[s]] = slot_work[s][head[s]] - 1'b1;
							ev.event_res = EV_SERVED;
							ev.remaining_work = slot_work[s][head[s]];
						end else begin
							head[s] = (head[s] + 1) % QUEUE_DEPTH;
							fill[s]--;
							departures++;
							ev.event_res = EV_DEPARTED;
						end
						ev.queue_length = QLEN_W'(fill[s]);
						events_due.push_back(ev);
					end
				end
			end
		endfunction

		function void check_event(input rsp_t got);
			rsp_t want;
			if (events_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: unexpected result ev=%0d id=%0d srv=%0d rem=%0d len=%0d last=%0b",
						$time, got.event_res, got.job_id, got.server, got.remaining_work,
						got.queue_length, got.last);
				return;
			end
			want = events_due.pop_front();
			checked++;
			if (got.event_res !== want.event_res || got.job_id !== want.job_id ||
				got.server !== want.server || got.remaining_work !== want.remaining_work ||
				got.queue_length !== want.queue_length || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t: result mismatch", $time);
					$display("  want ev=%0d id=%0d srv=%0d rem=%0d len=%0d last=%0b",
						want.event_res, want.job_id, want.server, want.remaining_work,
						want.queue_length, want.last);
					$display("  got  ev=%0d id=%0d srv=%0d rem=%0d len=%0d last=%0b",
						got.event_res, got.job_id, got.server, got.remaining_work,
						got.queue_length, got.last);
				end
			end
		endfunction

		function int unsigned failures();
			return mismatches + events_due.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_t             req_data;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [ID_W-1:0]  cfg_data;

	bit               src_idle;
	bit               rsp_idle;
	int unsigned      hold_asked;
	int unsigned      limit_writes;
	dispatch_ledger   ledger;

	always #HALF_PERIOD clk = ~clk;

	shortest_queue_dispatcher_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	function automatic req_t arrival_word(input logic [WORK_IN_W-1:0] w);
		req_t item;
		item.operation = OP_ARRIVAL;
		item.work_amount = w;
		return item;
	endfunction

	// work field is don't-care on a tick; randomize it anyway
	function automatic req_t tick_word();
		req_t item;
		item.operation = OP_TICK;
		item.work_amount = WORK_IN_W'($urandom);
		return item;
	endfunction

	task automatic send_item(input req_t item);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_data  <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		ledger.note_request(item);
	endtask

	task automatic wait_results_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (ledger.pending() != 0);
	endtask

	task automatic set_job_limit(input logic [ID_W-1:0] value);
		wait_results_drained();
		// an all-empty tick leaves no result behind, so let the back settle
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ledger.set_limit(value);
		limit_writes++;
	endtask

	initial begin : result_sink
		int unsigned stall_left;
		int unsigned hold_done;
		stall_left = 0;
		hold_done = 0;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				ledger.check_event(rsp_data);
				stall_left = rsp_idle ? $urandom_range(0, 8) : 0;
			end
			if (hold_asked != hold_done) begin
				hold_done = hold_asked;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		req_t item;
		ledger = new();
		src_idle = 1'b1;
		rsp_idle = 1'b1;
		hold_asked = 0;
		limit_writes = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_data  <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		set_job_limit(16'hFFFF);

		// tick on empty FIFOs, ties across all servers, short jobs
		send_item(tick_word());
		send_item(arrival_word(8'h00));
		send_item(arrival_word(8'h03));
		send_item(arrival_word(8'h02));
		send_item(arrival_word(8'h01));
		send_item(arrival_word(8'h01));
		send_item(tick_word());
		send_item(tick_word());
		send_item(arrival_word(8'h00));
		send_item(arrival_word(8'h02));
		send_item(tick_word());
		send_item(tick_word());
		send_item(tick_word());
		send_item(arrival_word(8'h04));
		send_item(arrival_word(8'h03));

		// id limit: a few more accepted, then refused; limit zero refuses all
		set_job_limit(ID_W'(ledger.issued + 3));
		repeat (5) send_item(arrival_word(WORK_IN_W'($urandom_range(0, 3))));
		send_item(tick_word());
		set_job_limit('0);
		repeat (2) send_item(arrival_word(8'hFF));
		set_job_limit(16'hFFFF);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 16 == 0) begin
				src_idle = ($urandom_range(0, 3) != 0);
				rsp_idle = ($urandom_range(0, 3) != 0);
			end
			if (i == 12) begin
				src_idle = 1'b0;
				hold_asked++;
			end
			if (i == 24) wait_results_drained();
			if (i == 28) set_job_limit(ID_W'(ledger.issued + $urandom_range(2, 6)));
			if (i == 40) set_job_limit(16'hFFFF);
			if ($urandom_range(0, 99) < 55) begin
				if ($urandom_range(0, 7) == 0)
					item = arrival_word(WORK_IN_W'($urandom_range(4, 15)));
				else item = arrival_word(WORK_IN_W'($urandom_range(0, 3)));
			end else begin
				item = tick_word();
			end
			send_item(item);
		end

		// fill every FIFO to depth, overflow it, then drain back past the wrap
		src_idle = 1'b1;
		rsp_idle = 1'b1;
		while (ledger.fill_min() < QUEUE_DEPTH)
			send_item(arrival_word(8'h00));
		repeat (3) send_item(arrival_word(WORK_IN_W'($urandom)));
		while (ledger.fill_total() != 0) send_item(tick_word());
		send_item(tick_word());

		// extreme work amounts on empty FIFOs, left in place
		send_item(arrival_word(8'hFF));
		send_item(arrival_word(8'h80));
		send_item(arrival_word(8'h7F));
		send_item(arrival_word(8'h55));
		send_item(tick_word());
		send_item(tick_word());

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d arrivals (%0d refused at the id limit, %0d at a full FIFO)",
			ledger.arrivals, ledger.limit_refusals, ledger.full_refusals);
		$display("and %0d ticks with %0d departures; %0d results checked over %0d limit writes",
			ledger.ticks, ledger.departures, ledger.checked, limit_writes);
		if (ledger.failures() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d failures, %0d results still pending", ledger.failures(),
				ledger.pending());
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin : watchdog
		#(10_000_000);
		$display("Timeout with %0d results pending", ledger.pending());
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
src/sqd_pkg.sv
src/sqd_front.sv
src/sqd_cmd_fifo.sv
src/sqd_back.sv
src/shortest_queue_dispatcher_top.sv
sim/testbench.sv
